@@ hdl/multi_button_debounce_autorepeat_core_macros.svh @@
// Assertion macros shared by the checker of the button debounce core.
// No dependencies; include by bare file name.
`ifndef MULTI_BUTTON_DEBOUNCE_AUTOREPEAT_CORE_MACROS_SVH
`define MULTI_BUTTON_DEBOUNCE_AUTOREPEAT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MBDA_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbda assertion failed");

// Next-cycle implication, disabled during reset.
`define MBDA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbda assertion failed");

// Next-cycle implication that is checked during reset as well.
`define MBDA_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mbda assertion failed");

`endif

@@ hdl/mbda_pkg.sv @@
// Types and constants of the button debounce and auto-repeat core.
// No dependencies; used by all modules of the block.
package mbda_pkg;

   localparam int CNT_W   = 16;
   localparam int PIN_W   = 8;
   localparam int IDX_W   = 4;
   localparam int QUERY_SLOTS = 2 ** IDX_W;
   localparam int TDATA_W = 16;

   localparam logic [CNT_W-1:0] DELAY_RESET    = 16'd200;
   localparam logic [CNT_W-1:0] INTERVAL_RESET = 16'd50;

   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_FIRST_DELAY     = 1'b0,
      CSR_REPEAT_INTERVAL = 1'b1
   } csr_index_type;

   // Per-button control from the top level.
   typedef struct packed {
      logic tick;
      logic clear;
      logic level;
   } btn_ctrl_type;

   // Per-button status back to the top level.
   typedef struct packed {
      logic flag;
      logic flag_next;
   } btn_stat_type;

   typedef struct packed {
      logic [PIN_W-1:0] pending_flags;
      logic             pressed;
   } rsp_type;

endpackage

@@ hdl/mbda_button.sv @@
// One button: three-sample debounce history, stable level and repeat countdown.
// Depends on mbda_pkg.
module mbda_button (
   input  logic                         clock,
   input  logic                         reset,
   input  mbda_pkg::btn_ctrl_type       ctrl,
   input  logic [mbda_pkg::CNT_W-1:0]   first_delay,
   input  logic [mbda_pkg::CNT_W-1:0]   interval,
   output mbda_pkg::btn_stat_type       stat
);

   logic                       newest_ff, newest_in;
   logic                       middle_ff, middle_in;
   logic                       stable_ff, stable_in;
   logic                       flag_ff, flag_in;
   logic [mbda_pkg::CNT_W-1:0] count_ff, count_in;
   logic [mbda_pkg::CNT_W-1:0] count_dec;
   logic                       agree;
   logic                       set_flag;

   // After the shift the three samples are level, newest and middle.
   assign agree     = (ctrl.level == newest_ff) && (newest_ff == middle_ff);
   assign count_dec = count_ff - mbda_pkg::CNT_W'(1);

   always_comb begin
      newest_in = newest_ff;
      middle_in = middle_ff;
      stable_in = stable_ff;
      count_in  = count_ff;
      set_flag  = 1'b0;
      if (ctrl.tick) begin
         newest_in = ctrl.level;
         middle_in = newest_ff;
         if (agree && (stable_ff != middle_ff)) begin
            stable_in = middle_ff;
            if (middle_ff == mbda_pkg::LEVEL_PRESSED) begin
               count_in = first_delay;
               set_flag = 1'b1;
            end
         end else if (agree && (stable_ff == mbda_pkg::LEVEL_PRESSED)) begin
            if (count_dec == '0) begin
               count_in = interval;
               set_flag = 1'b1;
            end else begin
               count_in = count_dec;
            end
         end
      end
   end

   always_comb begin
      flag_in = flag_ff;
      if (ctrl.tick) begin
         flag_in = flag_ff | set_flag;
      end else if (ctrl.clear) begin
         flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff <= mbda_pkg::LEVEL_RELEASED;
         middle_ff <= mbda_pkg::LEVEL_RELEASED;
         stable_ff <= mbda_pkg::LEVEL_RELEASED;
         count_ff  <= mbda_pkg::DELAY_RESET;
         flag_ff   <= 1'b0;
      end else begin
         newest_ff <= newest_in;
         middle_ff <= middle_in;
         stable_ff <= stable_in;
         count_ff  <= count_in;
         flag_ff   <= flag_in;
      end
   end

   assign stat.flag      = flag_ff;
   assign stat.flag_next = flag_in;

endmodule

@@ hdl/multi_button_debounce_autorepeat_core.sv @@
// Top level of the button debounce and auto-repeat core.
// Depends on mbda_pkg and mbda_button.
//
// The core takes one item per clock cycle while req_tready is high and returns
// one registered result per item, in order. A sample tick updates every button
// at once; a query reads and clears one button's pending flag. The result
// path is a two-entry output register (main plus skid), so req_tready stays
// high while one finished result waits for rsp_tready and drops only when
// both entries are full. No clearing pass is needed after reset.
module multi_button_debounce_autorepeat_core #(
   parameter int NUM_BUTTONS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: pin_levels [7:0], query_button [11:8], zero [15:12]
   input  logic [mbda_pkg::TDATA_W-1:0]   req_tdata,
   // tuser: cmd [0]
   input  logic                           req_tuser,
   // Result channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: pressed [0], pending_flags [8:1], zero [15:9]
   output logic [mbda_pkg::TDATA_W-1:0]   rsp_tdata,
   // Configuration port.
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [mbda_pkg::CNT_W-1:0]     csr_wdata
);

   localparam int RSP_W = $bits(mbda_pkg::rsp_type);

   logic [mbda_pkg::CNT_W-1:0] first_delay_ff;
   logic [mbda_pkg::CNT_W-1:0] interval_ff;

   logic                          accept;
   logic                          taken;
   logic                          is_query;
   logic [mbda_pkg::PIN_W-1:0]    pins;
   logic [mbda_pkg::IDX_W-1:0]    query_idx;
   logic [mbda_pkg::QUERY_SLOTS-1:0] flag_pad;
   logic [mbda_pkg::PIN_W-1:0]    pending_next;
   mbda_pkg::rsp_type             rsp_new;

   mbda_pkg::btn_ctrl_type        ctrl  [NUM_BUTTONS];
   mbda_pkg::btn_stat_type        stat  [NUM_BUTTONS];

   logic                          out_valid_ff, out_valid_in;
   logic                          skid_valid_ff, skid_valid_in;
   mbda_pkg::rsp_type             out_data_ff, out_data_in;
   mbda_pkg::rsp_type             skid_data_ff, skid_data_in;

   assign accept    = req_tvalid && req_tready;
   assign taken     = out_valid_ff && rsp_tready;
   assign is_query  = (mbda_pkg::cmd_type'(req_tuser) == mbda_pkg::CMD_QUERY);
   assign pins      = req_tdata[mbda_pkg::PIN_W-1:0];
   assign query_idx = req_tdata[mbda_pkg::PIN_W +: mbda_pkg::IDX_W];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff <= mbda_pkg::DELAY_RESET;
         interval_ff    <= mbda_pkg::INTERVAL_RESET;
      end else if (csr_we) begin
         unique case (mbda_pkg::csr_index_type'(csr_index))
            mbda_pkg::CSR_FIRST_DELAY:     first_delay_ff <= csr_wdata;
            mbda_pkg::CSR_REPEAT_INTERVAL: interval_ff    <= csr_wdata;
         endcase
      end
   end

   // Button cells. Buttons beyond the pin field always sample released, and
   // buttons beyond the query field can never be cleared.
   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
      assign ctrl[b].tick = accept && !is_query;
      if (b < mbda_pkg::PIN_W) begin : g_pin
         assign ctrl[b].level = pins[b];
      end else begin : g_nopin
         assign ctrl[b].level = mbda_pkg::LEVEL_RELEASED;
      end
      if (b < mbda_pkg::QUERY_SLOTS) begin : g_clr
         assign ctrl[b].clear = accept && is_query &&
                                (query_idx == mbda_pkg::IDX_W'(b));
      end else begin : g_noclr
         assign ctrl[b].clear = 1'b0;
      end

      mbda_button u_button (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl[b]),
         .first_delay (first_delay_ff),
         .interval    (interval_ff),
         .stat        (stat[b])
      );
   end

   for (genvar j = 0; j < mbda_pkg::QUERY_SLOTS; j++) begin : g_pad
      if (j < NUM_BUTTONS) begin : g_on
         assign flag_pad[j] = stat[j].flag;
      end else begin : g_off
         assign flag_pad[j] = 1'b0;
      end
   end

   for (genvar j = 0; j < mbda_pkg::PIN_W; j++) begin : g_pend
      if (j < NUM_BUTTONS) begin : g_on
         assign pending_next[j] = stat[j].flag_next;
      end else begin : g_off
         assign pending_next[j] = 1'b0;
      end
   end

   assign rsp_new.pressed       = is_query && flag_pad[query_idx];
   assign rsp_new.pending_flags = pending_next;

   // Two-entry output register. The skid entry only fills when a result is
   // waiting and another transfer arrives in the same cycle.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (taken) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || taken) begin
            out_valid_in = 1'b1;
            out_data_in  = rsp_new;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = rsp_new;
         end
      end else if (taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(mbda_pkg::TDATA_W-RSP_W){1'b0}}, out_data_ff};

endmodule

@@ hdl/mbda_checker.sv @@
// Port-level checker for the button debounce core, bound to its top level.
// Depends on mbda_pkg and multi_button_debounce_autorepeat_core_macros.svh.
`include "multi_button_debounce_autorepeat_core_macros.svh"

module mbda_checker #(
   parameter int NUM_BUTTONS = 8
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [mbda_pkg::TDATA_W-1:0] rsp_tdata
);

   logic [mbda_pkg::PIN_W-1:0] valid_mask;

   for (genvar j = 0; j < mbda_pkg::PIN_W; j++) begin : g_mask
      assign valid_mask[j] = (j < NUM_BUTTONS);
   end

   // No result is presented right after reset.
   `MBDA_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid)

   // A waiting result or a new transfer is never dropped while the sink stalls.
   `MBDA_ASSERT_NEXT(a_no_loss, clock, reset,
      (rsp_tvalid || (req_tvalid && req_tready)) && !rsp_tready, rsp_tvalid)

   // Backpressure on the request side only when a result is already waiting.
   `MBDA_ASSERT_NOW(a_ready_backpressure, clock, reset, !req_tready, rsp_tvalid)

   // Flags of buttons that do not exist stay clear.
   `MBDA_ASSERT_NOW(a_flags_in_range, clock, reset, rsp_tvalid,
      (rsp_tdata[8:1] & ~valid_mask) == '0)

endmodule

bind multi_button_debounce_autorepeat_core mbda_checker #(
   .NUM_BUTTONS (NUM_BUTTONS)
) u_mbda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
